@@ design/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

   // Store geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int FILL_W   = 5;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_LIST   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_INSERTED   = 3'd0,
      ST_FULL       = 3'd1,
      ST_POPPED     = 3'd2,
      ST_POP_EMPTY  = 3'd3,
      ST_LISTED     = 3'd4,
      ST_LIST_EMPTY = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] stime;
      logic [15:0] tag;
   } entry_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_LIST = 1'b1
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       ins;       // insert the request entry into the store
      logic       pop;       // drop the head entry, shift the rest forward
      logic       load;      // load the response register
      status_type status;
      logic       show;      // response carries an entry (head on pop, else list index)
      logic       last;
      logic       idx_clr;
      logic       idx_inc;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic out_free;   // response register empty or being taken this cycle
      logic idx_last;   // list index points at the last stored entry
   } stat_type;

endpackage

`default_nettype wire

@@ design/spq_if.sv @@
`default_nettype none

// Request channel
interface spq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  prio_value;
   logic [15:0] slot_time;
   logic [15:0] tag_id;

   modport source (output valid, output opcode, output prio_value, output slot_time,
                   output tag_id, input ready);
   modport sink   (input valid, input opcode, input prio_value, input slot_time,
                   input tag_id, output ready);
endinterface

// Response channel
interface spq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  out_prio;
   logic [15:0] out_time;
   logic [15:0] out_tag;
   logic [4:0]  fill_level;
   logic        last_flag;

   modport source (output valid, output status, output out_prio, output out_time,
                   output out_tag, output fill_level, output last_flag, input ready);
   modport sink   (input valid, input status, input out_prio, input out_time,
                   input out_tag, input fill_level, input last_flag, output ready);
endinterface

`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// Channel   Dir  Handshake    Payload
// req_bus   in   valid/ready  opcode, prio_value, slot_time, tag_id
// rsp_bus   out  valid/ready  status, out_prio, out_time, out_tag, fill_level, last_flag
//
// Insert, pop, empty list and full reject: one beat, registered at the accepting edge,
// so a request is taken every cycle the response register is free.
// List of n entries: the accepting edge clears the index counter, then n beats follow,
// one per cycle while the response register is free, paced by the index counter that
// walks the entry row; no request is taken during the walk.
// Response stalls hold the beat in the output register and hold off new requests.
// Reset clears the fill count, the controller state and the response valid; the
// entry row needs no clearing since only entries below the fill count are read.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   spq_req_if.sink    req_bus,
   spq_rsp_if.source  rsp_bus
);

   cmd_type    cmd;
   stat_type   stat;
   logic       req_ready;
   status_type rsp_status;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_prio   (req_bus.prio_value),
      .req_time   (req_bus.slot_time),
      .req_tag    (req_bus.tag_id),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_status (rsp_status),
      .rsp_prio   (rsp_bus.out_prio),
      .rsp_time   (rsp_bus.out_time),
      .rsp_tag    (rsp_bus.out_tag),
      .rsp_fill   (rsp_bus.fill_level),
      .rsp_last   (rsp_bus.last_flag)
   );

   assign req_bus.ready  = req_ready;
   assign rsp_bus.status = rsp_status;

endmodule

`default_nettype wire

@@ design/spq_ctrl.sv @@
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_opcode,
   output logic            req_ready,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   state_type  state_ff, state_in;
   opcode_type op;
   logic       accept;

   assign op        = opcode_type'(req_opcode);
   assign req_ready = (state_ff == S_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (op == OP_LIST) && !stat.empty) begin
               state_in = S_LIST;
            end
         end
         S_LIST: begin
            if (stat.out_free && stat.idx_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_INSERT: begin
                     cmd.load = 1'b1;
                     cmd.last = 1'b1;
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.ins    = 1'b1;
                        cmd.status = ST_INSERTED;
                     end
                  end
                  OP_POP: begin
                     cmd.load = 1'b1;
                     cmd.last = 1'b1;
                     if (stat.empty) begin
                        cmd.status = ST_POP_EMPTY;
                     end else begin
                        cmd.pop    = 1'b1;
                        cmd.show   = 1'b1;
                        cmd.status = ST_POPPED;
                     end
                  end
                  OP_LIST: begin
                     if (stat.empty) begin
                        cmd.load   = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.status = ST_LIST_EMPTY;
                     end else begin
                        cmd.idx_clr = 1'b1;
                     end
                  end
                  OP_NONE: begin
                     cmd = '0;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         S_LIST: begin
            if (stat.out_free) begin
               cmd.load    = 1'b1;
               cmd.show    = 1'b1;
               cmd.status  = ST_LISTED;
               cmd.last    = stat.idx_last;
               cmd.idx_inc = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   // Checks
   a_no_accept_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> !req_ready)
      else $error("request taken while listing");

   a_list_needs_entries: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_LIST) |-> !stat.empty)
      else $error("list walk started on empty store");

   a_list_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_LIST) && cmd.load && cmd.last) |=> (state_ff == S_IDLE))
      else $error("list walk did not end after last beat");

endmodule

`default_nettype wire

@@ design/spq_dpath.sv @@
`default_nettype none

module spq_dpath
   import spq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [7:0]  req_prio,
   input  wire logic [15:0] req_time,
   input  wire logic [15:0] req_tag,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output status_type       rsp_status,
   output logic [7:0]       rsp_prio,
   output logic [15:0]      rsp_time,
   output logic [15:0]      rsp_tag,
   output logic [FILL_W-1:0] rsp_fill,
   output logic             rsp_last
);

   entry_type             store_ff [CAPACITY];
   entry_type             store_in [CAPACITY];
   cnt_type               count_ff, count_in;
   idx_type               idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   entry_type             rsp_entry_ff, rsp_entry_in;
   logic [FILL_W-1:0]     rsp_fill_ff;
   logic                  rsp_last_ff;
   logic [CAPACITY-1:0]   gt;
   entry_type             new_entry;

   assign new_entry = '{prio: req_prio, stime: req_time, tag: req_tag};

   // Status toward the controller
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == cnt_type'(CAPACITY));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.idx_last = ((cnt_type'(idx_ff) + cnt_type'(1)) == count_ff);

   // Per-entry compare: stored entry is served after the new one
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i] = (cnt_type'(i) < count_ff) && (store_ff[i].prio > req_prio);
      end
   end

   // Shift the row open on insert, close it on pop
   always_comb begin
      store_in = store_ff;
      if (cmd.ins) begin
         if (gt[0] || (count_ff == '0)) begin
            store_in[0] = new_entry;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (gt[i-1]) begin
               store_in[i] = store_ff[i-1];
            end else if (gt[i] || (cnt_type'(i) == count_ff)) begin
               store_in[i] = new_entry;
            end
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            store_in[i] = store_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   // Fill count and list index
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + cnt_type'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - cnt_type'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // Response register: hold until the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_entry_in = '0;
      if (cmd.show) begin
         rsp_entry_in = cmd.pop ? store_ff[0] : store_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff <= cmd.status;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_fill_ff   <= FILL_W'(count_in);
         rsp_last_ff   <= cmd.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_prio   = rsp_entry_ff.prio;
   assign rsp_time   = rsp_entry_ff.stime;
   assign rsp_tag    = rsp_entry_ff.tag;
   assign rsp_fill   = rsp_fill_ff;
   assign rsp_last   = rsp_last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(CAPACITY))
      else $error("fill count above capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> stat.out_free)
      else $error("response overwritten before taken");

   a_ins_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> (count_ff == cnt_type'($past(count_ff) + cnt_type'(1))))
      else $error("insert did not advance fill count");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff > cnt_type'(1)) |-> (store_ff[0].prio <= store_ff[1].prio))
      else $error("head entry out of order");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.idx_inc |-> (cnt_type'(idx_ff) < count_ff))
      else $error("list index beyond fill count");

endmodule

`default_nettype wire

@@ verif/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int IDLE_LIMIT  = 500;
   localparam int TAIL_CYCLES = 20;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      status_type        status;
      entry_type         ent;
      logic [FILL_W-1:0] fill;
      logic              last;
   } rsp_beat_type;

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   entry_type    queue_image[$];   // predicted contents of the entry row, head first
   rsp_beat_type pending_rsp[$];   // response beats still owed by the block
   rsp_beat_type exp_beat;
   int           fail_cnt    = 0;
   int           idle_cycles = 0;
   int           stall_left  = 0;
   bit           gaps_on     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the response beats one accepted request causes
   function automatic void predict_beats(input opcode_type op, input entry_type e);
      int           pos;
      rsp_beat_type b;
      b = '0;
      b.last = 1'b1;
      case (op)
         OP_INSERT: begin
            if (queue_image.size() >= CAPACITY) begin
               b.status = ST_FULL;
            end else begin
               // place after every entry of equal or lower value
               pos = queue_image.size();
               for (int i = 0; i < queue_image.size(); i++) begin
                  if (queue_image[i].prio > e.prio) begin
                     pos = i;
                     break;
                  end
               end
               queue_image.insert(pos, e);
               b.status = ST_INSERTED;
            end
            b.fill = FILL_W'(queue_image.size());
            pending_rsp.push_back(b);
         end
         OP_POP: begin
            if (queue_image.size() == 0) begin
               b.status = ST_POP_EMPTY;
            end else begin
               b.ent    = queue_image.pop_front();
               b.status = ST_POPPED;
            end
            b.fill = FILL_W'(queue_image.size());
            pending_rsp.push_back(b);
         end
         OP_LIST: begin
            b.fill = FILL_W'(queue_image.size());
            if (queue_image.size() == 0) begin
               b.status = ST_LIST_EMPTY;
               pending_rsp.push_back(b);
            end else begin
               b.status = ST_LISTED;
               for (int i = 0; i < queue_image.size(); i++) begin
                  b.ent  = queue_image[i];
                  b.last = (i == queue_image.size() - 1);
                  pending_rsp.push_back(b);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void note_fail(input string msg);
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endfunction

   // Drive one request beat and hold it until the block takes it
   task automatic send_beat(input opcode_type op, input logic [7:0] prio,
                            input logic [15:0] stime, input logic [15:0] tag);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.prio_value <= prio;
      req_bus.slot_time  <= stime;
      req_bus.tag_id     <= tag;
      do @(posedge clock); while (!req_bus.ready);
      predict_beats(op, '{prio: prio, stime: stime, tag: tag});
   endtask

   task automatic send_insert(input logic [7:0] prio, input logic [15:0] stime,
                              input logic [15:0] tag);
      send_beat(OP_INSERT, prio, stime, tag);
   endtask

   // Pop and list carry junk in the unused fields
   task automatic send_plain(input opcode_type op);
      send_beat(op, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Hold off requests until every owed beat has come back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int ins_pct, input int prio_span);
      int         r;
      opcode_type op;
      r = $urandom_range(0, 99);
      if (r < 4)                                   op = OP_NONE;
      else if (r < 4 + ins_pct)                    op = OP_INSERT;
      else if (r < 4 + ins_pct + (96 - ins_pct) * 2 / 3) op = OP_POP;
      else                                         op = OP_LIST;
      send_beat(op, 8'($urandom_range(0, prio_span)), 16'($urandom), 16'($urandom));
   endtask

   task automatic test_empty_ops();
      send_plain(OP_POP);
      send_plain(OP_LIST);
      send_plain(OP_NONE);
      send_plain(OP_POP);
   endtask

   // Extremes and ties; equal priorities must leave in arrival order
   task automatic test_ordering();
      send_insert(8'd0, 16'h0000, 16'h0000);
      send_insert(8'd255, 16'hFFFF, 16'hFFFF);
      send_insert(8'd7, 16'h0001, 16'hA5A5);
      send_insert(8'd7, 16'h0002, 16'h5A5A);
      send_insert(8'd7, 16'h0003, 16'hFF00);
      send_insert(8'd0, 16'h00FF, 16'h00FF);
      send_plain(OP_LIST);
      send_plain(OP_POP);
      send_plain(OP_POP);
      send_plain(OP_NONE);
      send_plain(OP_LIST);
      repeat (4) send_plain(OP_POP);
      send_plain(OP_POP);
      send_plain(OP_LIST);
   endtask

   // Fill to capacity, reject further inserts, then drain past empty
   task automatic test_full_reject();
      repeat (CAPACITY) send_insert(8'($urandom), 16'($urandom), 16'($urandom));
      send_insert(8'd0, 16'hFFFF, 16'hFFFF);
      send_insert(8'd255, 16'h0000, 16'h0000);
      send_plain(OP_LIST);
      send_plain(OP_NONE);
      repeat (CAPACITY + 1) send_plain(OP_POP);
   endtask

   task automatic test_hold_off();
      repeat (4) send_insert(8'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      wait_drained();
      send_plain(OP_LIST);
      wait_drained();
      repeat (5) send_plain(OP_POP);
   endtask

   task automatic test_random();
      int ins_pct;
      int prio_span;
      for (int chunk = 0; chunk < 9; chunk++) begin
         case ($urandom_range(0, 2))
            0:       ins_pct = 30;
            1:       ins_pct = 50;
            default: ins_pct = 80;
         endcase
         prio_span = ($urandom_range(0, 1) == 0) ? 3 : 255;
         repeat (40) send_random(ins_pct, prio_span);
         if (chunk == 4) wait_drained();
      end
   endtask

   task automatic test_no_idle();
      gaps_on = 1'b0;
      repeat (60) send_random(50, 255);
   endtask

   // Stall the response side in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each response beat with the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            note_fail($sformatf("unexpected response beat status=%0d prio=%0d time=%0h tag=%0h",
                                rsp_bus.status, rsp_bus.out_prio, rsp_bus.out_time,
                                rsp_bus.out_tag));
         end else begin
            exp_beat = pending_rsp.pop_front();
            if (rsp_bus.status !== exp_beat.status || rsp_bus.out_prio !== exp_beat.ent.prio ||
                rsp_bus.out_time !== exp_beat.ent.stime ||
                rsp_bus.out_tag !== exp_beat.ent.tag ||
                rsp_bus.fill_level !== exp_beat.fill ||
                rsp_bus.last_flag !== exp_beat.last) begin
               note_fail($sformatf({"beat differs: exp st=%0d prio=%0d time=%0h tag=%0h ",
                                    "fill=%0d last=%0b / act st=%0d prio=%0d time=%0h ",
                                    "tag=%0h fill=%0d last=%0b"},
                                   exp_beat.status, exp_beat.ent.prio, exp_beat.ent.stime,
                                   exp_beat.ent.tag, exp_beat.fill, exp_beat.last,
                                   rsp_bus.status, rsp_bus.out_prio, rsp_bus.out_time,
                                   rsp_bus.out_tag, rsp_bus.fill_level, rsp_bus.last_flag));
            end
         end
      end
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_INSERT;
      req_bus.prio_value = '0;
      req_bus.slot_time  = '0;
      req_bus.tag_id     = '0;
      rsp_bus.ready      = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_ops();
      test_ordering();
      test_full_reject();
      test_hold_off();
      test_random();
      test_no_idle();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_cnt == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
